// ----- rtl/lcdc_pkg.sv -----
package lcdc_pkg;

    localparam int GRAM_WIDTH   = 240;
    localparam int GRAM_HEIGHT  = 320;
    localparam int PANEL_WIDTH  = 240;
    localparam int PANEL_HEIGHT = 320;
    localparam int GRAM_DEPTH   = GRAM_WIDTH * GRAM_HEIGHT;
    localparam int ADDR_W       = $clog2(GRAM_DEPTH);
    localparam int CLR_W        = $clog2(GRAM_DEPTH + 1);

    localparam logic [7:0] CMD_SWRESET = 8'h01;
    localparam logic [7:0] CMD_SLPIN   = 8'h10;
    localparam logic [7:0] CMD_SLPOUT  = 8'h11;
    localparam logic [7:0] CMD_INVOFF  = 8'h20;
    localparam logic [7:0] CMD_INVON   = 8'h21;
    localparam logic [7:0] CMD_DISPOFF = 8'h28;
    localparam logic [7:0] CMD_DISPON  = 8'h29;
    localparam logic [7:0] CMD_CASET   = 8'h2A;
    localparam logic [7:0] CMD_RASET   = 8'h2B;
    localparam logic [7:0] CMD_RAMWR   = 8'h2C;
    localparam logic [7:0] CMD_MADCTL  = 8'h36;
    localparam logic [7:0] CMD_COLMOD  = 8'h3A;

    localparam logic [3:0]  FMT_RGB565 = 4'h5;
    localparam int          MADCTL_BGR = 3;
    localparam logic [31:0] BLACK_ARGB = 32'hFF00_0000;

    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] REG_SHOW_GRAM = 2'd0;

    localparam logic [15:0] XEND_RST = 16'(GRAM_WIDTH - 1);
    localparam logic [15:0] YEND_RST = 16'(GRAM_HEIGHT - 1);

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
        logic [7:0] pixel_x;
        logic [8:0] pixel_y;
    } item_t;

endpackage

// ----- rtl/lcdc_fifo.sv -----
module lcdc_fifo
    import lcdc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);
    item_t      mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- rtl/lcdc_back.sv -----
module lcdc_back
    import lcdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        show_gram,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_data
);
    logic [15:0] gram [GRAM_DEPTH];

    logic [7:0]  cmd_reg;
    logic [4:0]  argc_reg;
    logic [7:0]  args_reg [4];
    logic [15:0] xs_reg, xe_reg, ys_reg, ye_reg;
    logic [16:0] cx_reg, cy_reg;
    logic [7:0]  madctl_reg, colmod_reg;
    logic        awake_reg, disp_reg, inv_reg;
    logic [7:0]  part_reg [2];
    logic [1:0]  pcnt_reg;
    logic [CLR_W-1:0] clr_reg;
    logic        clearing;

    // read pipeline: s1 = RAM read, s2 = output reg
    logic        s1_v_reg, s1_blk_reg;
    logic [15:0] rd_reg;
    logic        o_v_reg;
    logic [31:0] o_reg;
    logic        stall;

    logic        take;
    logic        wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;

    logic [4:0]  argc_next;
    logic        need2;
    logic [15:0] pix;
    logic        pix_done;
    logic [16:0] cx1, cy1;
    logic [16:0] cx_next, cy_next;
    logic        rd_blk;
    logic [15:0] p;
    logic [7:0]  r8, g8, b8;
    logic        caset_done, raset_done;

    assign clearing  = (clr_reg != CLR_W'(GRAM_DEPTH));
    assign stall     = o_v_reg && !out_ready;
    assign in_ready  = !clearing && !stall;
    assign take      = in_valid && in_ready;
    assign out_valid = o_v_reg;
    assign out_data  = o_reg;

    assign argc_next = (argc_reg < 5'd17) ? argc_reg + 5'd1 : argc_reg;
    assign need2     = (colmod_reg[3:0] == FMT_RGB565);
    assign pix_done  = need2 ? (pcnt_reg >= 2'd1) : (pcnt_reg >= 2'd2);
    assign pix = need2 ? {part_reg[0], in_item.byte_value}
                       : {part_reg[0][7:3], part_reg[1][7:2], in_item.byte_value[7:3]};

    assign caset_done = (argc_reg >= 5'd4) && (cmd_reg == CMD_CASET);
    assign raset_done = (argc_reg >= 5'd4) && (cmd_reg == CMD_RASET);

    always_comb
    begin
        cx1 = cx_reg + 17'd1;
        cx_next = cx1;
        cy_next = cy_reg;
        if (cx1 > {1'b0, xe_reg})
        begin
            cx_next = {1'b0, xs_reg};
            cy1 = cy_reg + 17'd1;
            cy_next = (cy1 > {1'b0, ye_reg}) ? {1'b0, ys_reg} : cy1;
        end
        else
        begin
            cy1 = cy_reg;
        end
    end

    assign wr_addr = clearing ? ADDR_W'(clr_reg)
                   : ADDR_W'(cy_reg[ADDR_W-1:0] * ADDR_W'(GRAM_WIDTH) + ADDR_W'(cx_reg));
    assign wr_en = clearing || (take && in_item.mode == MODE_DATA && cmd_reg == CMD_RAMWR
                   && pix_done && cx_reg < 17'(GRAM_WIDTH) && cy_reg < 17'(GRAM_HEIGHT));
    assign wr_data = clearing ? 16'd0 : pix;

    assign rd_addr = ADDR_W'(in_item.pixel_y * ADDR_W'(GRAM_WIDTH) + ADDR_W'(in_item.pixel_x));
    assign rd_blk  = ((!awake_reg || !disp_reg) && !show_gram)
                   || in_item.pixel_x >= 8'(PANEL_WIDTH > 255 ? 255 : PANEL_WIDTH)
                      && PANEL_WIDTH <= 255
                   || 32'(in_item.pixel_x) >= 32'(GRAM_WIDTH)
                   || 32'(in_item.pixel_x) >= 32'(PANEL_WIDTH)
                   || 32'(in_item.pixel_y) >= 32'(PANEL_HEIGHT)
                   || 32'(in_item.pixel_y) >= 32'(GRAM_HEIGHT);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gram[wr_addr] <= wr_data;
        end
        if (!stall)
        begin
            rd_reg <= gram[rd_addr];
        end
    end

    assign p  = inv_reg ? ~rd_reg : rd_reg;
    assign r8 = {p[15:11], p[15:13]};
    assign g8 = {p[10:5], p[10:9]};
    assign b8 = {p[4:0], p[4:2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            cmd_reg    <= '0;
            argc_reg   <= '0;
            xs_reg     <= '0;
            xe_reg     <= XEND_RST;
            ys_reg     <= '0;
            ye_reg     <= YEND_RST;
            cx_reg     <= '0;
            cy_reg     <= '0;
            madctl_reg <= '0;
            colmod_reg <= '0;
            awake_reg  <= 1'b0;
            disp_reg   <= 1'b0;
            inv_reg    <= 1'b0;
            pcnt_reg   <= '0;
            s1_v_reg   <= 1'b0;
            s1_blk_reg <= 1'b0;
            o_v_reg    <= 1'b0;
            o_reg      <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_reg <= clr_reg + CLR_W'(1);
            end
            if (!stall)
            begin
                s1_v_reg   <= take && in_item.mode == MODE_READ;
                s1_blk_reg <= rd_blk;
                o_v_reg    <= s1_v_reg;
                if (s1_blk_reg)
                begin
                    o_reg <= BLACK_ARGB;
                end
                else if (madctl_reg[MADCTL_BGR])
                begin
                    o_reg <= {8'hFF, b8, g8, r8};
                end
                else
                begin
                    o_reg <= {8'hFF, r8, g8, b8};
                end
            end
            if (take && in_item.mode == MODE_CMD)
            begin
                if (in_item.byte_value == CMD_SWRESET)
                begin
                    xs_reg <= '0;
                    xe_reg <= XEND_RST;
                    ys_reg <= '0;
                    ye_reg <= YEND_RST;
                end
                else
                begin
                    if (caset_done)
                    begin
                        xs_reg <= {args_reg[0], args_reg[1]};
                        xe_reg <= {args_reg[2], args_reg[3]};
                    end
                    if (raset_done)
                    begin
                        ys_reg <= {args_reg[0], args_reg[1]};
                        ye_reg <= {args_reg[2], args_reg[3]};
                    end
                end
                if (in_item.byte_value == CMD_RAMWR)
                begin
                    cx_reg <= caset_done ? {1'b0, args_reg[0], args_reg[1]} : {1'b0, xs_reg};
                    cy_reg <= raset_done ? {1'b0, args_reg[0], args_reg[1]} : {1'b0, ys_reg};
                end
                else
                begin
                    if (caset_done)
                    begin
                        cx_reg <= {1'b0, args_reg[0], args_reg[1]};
                    end
                    if (raset_done)
                    begin
                        cy_reg <= {1'b0, args_reg[0], args_reg[1]};
                    end
                end
                cmd_reg  <= in_item.byte_value;
                argc_reg <= '0;
                pcnt_reg <= '0;
                unique case (in_item.byte_value)
                    CMD_SWRESET:
                    begin
                        madctl_reg <= '0;
                        awake_reg  <= 1'b0;
                        disp_reg   <= 1'b0;
                        inv_reg    <= 1'b0;
                    end
                    CMD_SLPIN:   awake_reg <= 1'b0;
                    CMD_SLPOUT:  awake_reg <= 1'b1;
                    CMD_INVOFF:  inv_reg   <= 1'b0;
                    CMD_INVON:   inv_reg   <= 1'b1;
                    CMD_DISPOFF: disp_reg  <= 1'b0;
                    CMD_DISPON:  disp_reg  <= 1'b1;
                    default: ;
                endcase
            end
            else if (take && in_item.mode == MODE_DATA)
            begin
                argc_reg <= argc_next;
                if (cmd_reg == CMD_RAMWR)
                begin
                    if (!pix_done)
                    begin
                        pcnt_reg <= pcnt_reg + 2'd1;
                    end
                    else
                    begin
                        pcnt_reg <= '0;
                        cx_reg   <= cx_next;
                        cy_reg   <= cy_next;
                    end
                end
                else if (argc_next == 5'd1)
                begin
                    if (cmd_reg == CMD_MADCTL)
                    begin
                        madctl_reg <= in_item.byte_value;
                    end
                    else if (cmd_reg == CMD_COLMOD)
                    begin
                        colmod_reg <= in_item.byte_value;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_item.mode == MODE_DATA)
        begin
            if (cmd_reg == CMD_RAMWR)
            begin
                if (!pix_done)
                begin
                    part_reg[pcnt_reg[0]] <= in_item.byte_value;
                end
            end
            else if (argc_next <= 5'd4)
            begin
                args_reg[argc_reg[1:0]] <= in_item.byte_value;
            end
        end
    end
endmodule

// ----- rtl/lcd_controller_command_and_gram.sv -----
// A scan-out read passes the queue, the RAM read register and the output register, in order.
// One word per cycle unless m_tready or clearing stalls; GRAM write, read ports run in parallel.
// Reset: rst_n is asynchronous, active low; it restores the power-on register state.
// After reset a clearing pass zeroes all GRAM_WIDTH*GRAM_HEIGHT = 76800 words of the frame store;
// meanwhile the queue takes at most two words; configuration writes are taken throughout.
module lcd_controller_command_and_gram
    import lcdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // mode[1:0]
    input  logic [31:0] s_tdata,   // byte_value[7:0], pixel_x[15:8], pixel_y[24:16], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // pixel_argb[31:0]
);
    logic  stay_reg;
    item_t in_item;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    assign pready = 1'b1;
    assign prdata = {31'd0, stay_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stay_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr == REG_SHOW_GRAM)
        begin
            stay_reg <= pwdata[0];
        end
    end

    assign in_item = '{mode: s_tuser, byte_value: s_tdata[7:0],
                       pixel_x: s_tdata[15:8], pixel_y: s_tdata[24:16]};

    lcdc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    lcdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .show_gram  (stay_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );
endmodule

// ----- rtl/lcdc_checker.sv -----
module lcdc_checker
    import lcdc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:24] == 8'hFF) else $error("alpha not opaque");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready low");
endmodule

bind lcd_controller_command_and_gram lcdc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .pready(pready)
);
